// File: rtl/dtpp_pkg.sv
// Shared types and constants for the disparity to point projection block.
package dtpp_pkg;

   // Field widths
   localparam int COORD_W = 12;
   localparam int DISP_W  = 12;
   localparam int COLOR_W = 8;
   localparam int CSR_W   = 16;
   localparam int XY_W    = 32;
   localparam int Z_W     = 20;
   localparam int RGB_W   = 3 * COLOR_W;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_Q4    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X_Q4 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y_Q4 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DEPTH   = 3'd4;

   // Register reset values
   localparam logic [CSR_W-1:0] FOCAL_Q4_RESET    = 16'd16000;
   localparam logic [CSR_W-1:0] BASELINE_RESET    = 16'd100;
   localparam logic [CSR_W-1:0] CENTER_X_Q4_RESET = 16'd0;
   localparam logic [CSR_W-1:0] CENTER_Y_Q4_RESET = 16'd0;
   localparam logic [CSR_W-1:0] MAX_DEPTH_RESET   = 16'd20000;

   // Offset from the principal point, 1/16 pixel, signed
   localparam int OFS_W = CSR_W + 1;

   // Per-pixel data carried alongside the X/Y projection
   typedef struct packed {
      logic             ok;
      logic [Z_W-1:0]   z;
      logic [RGB_W-1:0] rgb;
   } proj_side_type;

   // One finished point
   typedef struct packed {
      logic [XY_W-1:0]  x;
      logic [XY_W-1:0]  y;
      logic [Z_W-1:0]   z;
      logic [RGB_W-1:0] rgb;
      logic             pv;
   } point_type;

endpackage

// File: rtl/dtpp_divider.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
module dtpp_divider #(
   parameter int NUM_W  = 36,
   parameter int DEN_W  = 16,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);

   // Per-stage registers; the numerator shifts out of nq while quotient bits shift in
   logic [NUM_W-1:0]  vld_ff;
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  nq_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic              vld_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [NUM_W-1:0]  nq_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              fits;

      if (i == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign nq_prev   = in_num;
         assign den_prev  = in_den;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign nq_prev   = nq_ff[i-1];
         assign den_prev  = den_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      // Trial subtract of the divisor from the shifted remainder
      assign trial = {rem_prev, nq_prev[NUM_W-1]};
      assign diff  = trial - {1'b0, den_prev};
      assign fits  = (trial >= {1'b0, den_prev});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_ff[i]   <= {nq_prev[NUM_W-2:0], fits};
            den_ff[i]  <= den_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quot  = nq_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

   // A frozen pipeline keeps every valid bit
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("divider valid bits moved while stalled");

   // The last stage takes what the stage before it held
   a_shift_on_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid == $past(vld_ff[NUM_W-2]))
      else $error("divider dropped or invented an item");

endmodule

// File: rtl/dtpp_project.sv
// X/Y projection: offset times depth, divided by focal length, saturated to 32 bits.
module dtpp_project (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic signed [dtpp_pkg::OFS_W-1:0]   in_du,
   input  logic signed [dtpp_pkg::OFS_W-1:0]   in_dv,
   input  dtpp_pkg::proj_side_type             in_info,
   input  logic [dtpp_pkg::CSR_W-1:0]          focal,
   output logic                                out_valid,
   output dtpp_pkg::point_type                 out_point
);
   import dtpp_pkg::*;

   localparam int PROD_W = OFS_W + Z_W + 1;
   localparam int MAG_W  = OFS_W + Z_W - 1;
   localparam int XSIDE_W = $bits(proj_side_type) + 1;

   // Truncated quotient magnitude plus sign, saturated to the signed 32-bit range
   function automatic logic [XY_W-1:0] sat_q(input logic neg, input logic [MAG_W-1:0] mag);
      logic [MAG_W-1:0] neg_mag;
      logic [MAG_W-1:0] pos_lim;
      logic [MAG_W-1:0] neg_lim;
      neg_mag = ~mag + MAG_W'(1);
      pos_lim = MAG_W'({1'b0, {(XY_W-1){1'b1}}});
      neg_lim = MAG_W'({1'b1, {(XY_W-1){1'b0}}});
      if (!neg) begin
         return (mag > pos_lim) ? pos_lim[XY_W-1:0] : mag[XY_W-1:0];
      end else begin
         return (mag > neg_lim) ? neg_lim[XY_W-1:0] : neg_mag[XY_W-1:0];
      end
   endfunction

   // Stage A: products of offset and depth
   logic                     pa_valid_ff;
   logic signed [PROD_W-1:0] pa_prod_x_ff;
   logic signed [PROD_W-1:0] pa_prod_y_ff;
   proj_side_type            pa_info_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_valid_ff <= 1'b0;
      end else if (advance) begin
         pa_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pa_prod_x_ff <= in_du * $signed({1'b0, in_info.z});
         pa_prod_y_ff <= in_dv * $signed({1'b0, in_info.z});
         pa_info_ff   <= in_info;
      end
   end

   // Stage B: sign and magnitude
   logic              pb_valid_ff;
   logic              pb_neg_x_ff;
   logic              pb_neg_y_ff;
   logic [MAG_W-1:0]  pb_mag_x_ff;
   logic [MAG_W-1:0]  pb_mag_y_ff;
   proj_side_type     pb_info_ff;
   logic [PROD_W-1:0] abs_x;
   logic [PROD_W-1:0] abs_y;

   assign abs_x = pa_prod_x_ff[PROD_W-1] ? (~pa_prod_x_ff + PROD_W'(1)) : pa_prod_x_ff;
   assign abs_y = pa_prod_y_ff[PROD_W-1] ? (~pa_prod_y_ff + PROD_W'(1)) : pa_prod_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pb_valid_ff <= 1'b0;
      end else if (advance) begin
         pb_valid_ff <= pa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pb_neg_x_ff <= pa_prod_x_ff[PROD_W-1];
         pb_neg_y_ff <= pa_prod_y_ff[PROD_W-1];
         pb_mag_x_ff <= abs_x[MAG_W-1:0];
         pb_mag_y_ff <= abs_y[MAG_W-1:0];
         pb_info_ff  <= pa_info_ff;
      end
   end

   // Divide both magnitudes by the focal length
   logic               xd_valid;
   logic [MAG_W-1:0]   xd_quot;
   logic [XSIDE_W-1:0] xd_side;
   logic               yd_valid;
   logic [MAG_W-1:0]   yd_quot;
   logic               yd_neg;

   dtpp_divider #(
      .NUM_W  (MAG_W),
      .DEN_W  (CSR_W),
      .SIDE_W (XSIDE_W)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pb_valid_ff),
      .in_num    (pb_mag_x_ff),
      .in_den    (focal),
      .in_side   ({pb_neg_x_ff, pb_info_ff}),
      .out_valid (xd_valid),
      .out_quot  (xd_quot),
      .out_side  (xd_side)
   );

   dtpp_divider #(
      .NUM_W  (MAG_W),
      .DEN_W  (CSR_W),
      .SIDE_W (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pb_valid_ff),
      .in_num    (pb_mag_y_ff),
      .in_den    (focal),
      .in_side   (pb_neg_y_ff),
      .out_valid (yd_valid),
      .out_quot  (yd_quot),
      .out_side  (yd_neg)
   );

   // Stage C: restore sign, saturate, zero X/Y for invalid points or a zero focal length
   proj_side_type xd_info;
   logic          xd_neg;
   logic          zero_xy;
   logic          pc_valid_ff;
   point_type     pc_point_ff;
   point_type     pc_point_in;

   assign xd_info = proj_side_type'(xd_side[XSIDE_W-2:0]);
   assign xd_neg  = xd_side[XSIDE_W-1];
   assign zero_xy = !xd_info.ok || (focal == '0);

   always_comb begin
      pc_point_in.x   = zero_xy ? '0 : sat_q(xd_neg, xd_quot);
      pc_point_in.y   = zero_xy ? '0 : sat_q(yd_neg, yd_quot);
      pc_point_in.z   = xd_info.z;
      pc_point_in.rgb = xd_info.rgb;
      pc_point_in.pv  = xd_info.ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_valid_ff <= 1'b0;
      end else if (advance) begin
         pc_valid_ff <= xd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pc_point_ff <= pc_point_in;
      end
   end

   assign out_valid = pc_valid_ff;
   assign out_point = pc_point_ff;

   // Both dividers carry the same items in lockstep
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      xd_valid == yd_valid)
      else $error("X and Y dividers out of step");

endmodule

// File: rtl/disparity_to_point_projection.sv
// Top level: stereo disparity to 3-D point projection pipeline.
//
// Input channel req_*: one pixel per transfer (column, row, signed disparity in
// 1/16 pixel, RGB). Output channel rsp_*: one point per pixel, in input order.
// Both channels transfer when valid is high and stall is low.
// Configuration: csr_wr_en writes csr_wdata to the register at csr_index
// (focal, baseline, center x, center y, max depth); unknown indexes are dropped.
// Write only while no pixel is in flight.
//
// Throughput: one pixel per clock while req_stall is low. The path from the input
// transfer to rsp_valid runs through two 36-stage divider pipelines (depth, then
// X/Y) plus input, depth check, multiply, sign, saturate and output registers.
// When rsp_stall is high the pipeline keeps running until one more point fills
// the skid register; req_stall then rises until the skid drains. req_stall is
// a register output. Reset is synchronous: it empties the pipeline and loads
// the default camera registers.
module disparity_to_point_projection (
   input  logic                                 clock,
   input  logic                                 reset,
   // Configuration
   input  logic                                 csr_wr_en,
   input  logic [dtpp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dtpp_pkg::CSR_W-1:0]           csr_wdata,
   // Pixel input
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [dtpp_pkg::COORD_W-1:0]         req_column,
   input  logic [dtpp_pkg::COORD_W-1:0]         req_row,
   input  logic signed [dtpp_pkg::DISP_W-1:0]   req_disparity_q4,
   input  logic [dtpp_pkg::COLOR_W-1:0]         req_red,
   input  logic [dtpp_pkg::COLOR_W-1:0]         req_green,
   input  logic [dtpp_pkg::COLOR_W-1:0]         req_blue,
   // Point output
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [dtpp_pkg::XY_W-1:0]     rsp_x_q4,
   output logic signed [dtpp_pkg::XY_W-1:0]     rsp_y_q4,
   output logic [dtpp_pkg::Z_W-1:0]             rsp_z_q4,
   output logic [dtpp_pkg::RGB_W-1:0]           rsp_packed_rgb,
   output logic                                 rsp_point_valid
);
   import dtpp_pkg::*;

   localparam int PROD_W  = 2 * CSR_W;
   localparam int ZNUM_W  = PROD_W + 4;
   localparam int ZDEN_W  = DISP_W - 1;

   typedef struct packed {
      logic                    pos;
      logic signed [OFS_W-1:0] du;
      logic signed [OFS_W-1:0] dv;
      logic [RGB_W-1:0]        rgb;
   } depth_side_type;

   // Configuration registers
   logic [CSR_W-1:0] focal_q4_ff;
   logic [CSR_W-1:0] baseline_ff;
   logic [CSR_W-1:0] center_x_q4_ff;
   logic [CSR_W-1:0] center_y_q4_ff;
   logic [CSR_W-1:0] max_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_q4_ff    <= FOCAL_Q4_RESET;
         baseline_ff    <= BASELINE_RESET;
         center_x_q4_ff <= CENTER_X_Q4_RESET;
         center_y_q4_ff <= CENTER_Y_Q4_RESET;
         max_depth_ff   <= MAX_DEPTH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FOCAL_Q4:    focal_q4_ff    <= csr_wdata;
            CSR_BASELINE:    baseline_ff    <= csr_wdata;
            CSR_CENTER_X_Q4: center_x_q4_ff <= csr_wdata;
            CSR_CENTER_Y_Q4: center_y_q4_ff <= csr_wdata;
            CSR_MAX_DEPTH:   max_depth_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline moves whenever the skid register is empty
   logic skid_valid_ff;
   logic advance;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Stage 0: focal * baseline, disparity check, offsets from principal point
   logic              s0_valid_ff;
   logic [PROD_W-1:0] s0_prod_ff;
   logic [ZDEN_W-1:0] s0_den_ff;
   depth_side_type    s0_side_ff;
   depth_side_type    s0_side_in;

   always_comb begin
      s0_side_in.pos = !req_disparity_q4[DISP_W-1] && (req_disparity_q4 != '0);
      s0_side_in.du  = $signed({1'b0, req_column, 4'b0000}) - $signed({1'b0, center_x_q4_ff});
      s0_side_in.dv  = $signed({1'b0, req_row, 4'b0000}) - $signed({1'b0, center_y_q4_ff});
      s0_side_in.rgb = {req_red, req_green, req_blue};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_prod_ff <= focal_q4_ff * baseline_ff;
         s0_den_ff  <= req_disparity_q4[ZDEN_W-1:0];
         s0_side_ff <= s0_side_in;
      end
   end

   // Depth divider: 16 * focal * baseline / disparity
   logic              zd_valid;
   logic [ZNUM_W-1:0] zd_quot;
   depth_side_type    zd_side;

   dtpp_divider #(
      .NUM_W  (ZNUM_W),
      .DEN_W  (ZDEN_W),
      .SIDE_W ($bits(depth_side_type))
   ) u_div_z (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_valid_ff),
      .in_num    ({s0_prod_ff, 4'b0000}),
      .in_den    (s0_den_ff),
      .in_side   (s0_side_ff),
      .out_valid (zd_valid),
      .out_quot  (zd_quot),
      .out_side  (zd_side)
   );

   // Stage 1: depth limit check
   logic                    depth_ok;
   logic                    s1_valid_ff;
   logic signed [OFS_W-1:0] s1_du_ff;
   logic signed [OFS_W-1:0] s1_dv_ff;
   proj_side_type           s1_info_ff;
   proj_side_type           s1_info_in;

   assign depth_ok = zd_side.pos &&
                     (zd_quot <= ZNUM_W'({max_depth_ff, 4'b0000}));

   always_comb begin
      s1_info_in.ok  = depth_ok;
      s1_info_in.z   = depth_ok ? zd_quot[Z_W-1:0] : '0;
      s1_info_in.rgb = zd_side.rgb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= zd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_du_ff   <= zd_side.du;
         s1_dv_ff   <= zd_side.dv;
         s1_info_ff <= s1_info_in;
      end
   end

   // X/Y projection
   logic      fin_valid;
   point_type fin_point;

   dtpp_project u_project (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s1_valid_ff),
      .in_du     (s1_du_ff),
      .in_dv     (s1_dv_ff),
      .in_info   (s1_info_ff),
      .focal     (focal_q4_ff),
      .out_valid (fin_valid),
      .out_point (fin_point)
   );

   // Output register with skid
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   point_type rsp_point_ff;
   point_type rsp_point_in;
   logic      skid_valid_in;
   point_type skid_point_ff;
   point_type skid_point_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_point_in  = rsp_point_ff;
      skid_valid_in = skid_valid_ff;
      skid_point_in = skid_point_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_point_in  = skid_point_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = fin_valid;
            rsp_point_in = fin_point;
         end
      end else if (!skid_valid_ff && fin_valid) begin
         skid_valid_in = 1'b1;
         skid_point_in = fin_point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_point_ff  <= rsp_point_in;
      skid_point_ff <= skid_point_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_q4        = $signed(rsp_point_ff.x);
   assign rsp_y_q4        = $signed(rsp_point_ff.y);
   assign rsp_z_q4        = rsp_point_ff.z;
   assign rsp_packed_rgb  = rsp_point_ff.rgb;
   assign rsp_point_valid = rsp_point_ff.pv;

   // Skid only fills behind an occupied output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a point while output register is empty");

   // Skid is not drained while the receiver stalls
   a_skid_kept: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("skid point lost under stall");

   // An invalid point carries zero coordinates
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_point_valid |->
         rsp_x_q4 == '0 && rsp_y_q4 == '0 && rsp_z_q4 == '0)
      else $error("invalid point with nonzero coordinates");

endmodule

// File: sim/dtpp_point_checker.sv
// Point predictor and scoreboard for the disparity to point projection block.
module dtpp_point_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [dtpp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dtpp_pkg::CSR_W-1:0]           csr_wdata,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [dtpp_pkg::COORD_W-1:0]         req_column,
   input  logic [dtpp_pkg::COORD_W-1:0]         req_row,
   input  logic signed [dtpp_pkg::DISP_W-1:0]   req_disparity_q4,
   input  logic [dtpp_pkg::COLOR_W-1:0]         req_red,
   input  logic [dtpp_pkg::COLOR_W-1:0]         req_green,
   input  logic [dtpp_pkg::COLOR_W-1:0]         req_blue,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [dtpp_pkg::XY_W-1:0]     rsp_x_q4,
   input  logic signed [dtpp_pkg::XY_W-1:0]     rsp_y_q4,
   input  logic [dtpp_pkg::Z_W-1:0]             rsp_z_q4,
   input  logic [dtpp_pkg::RGB_W-1:0]           rsp_packed_rgb,
   input  logic                                 rsp_point_valid,
   output int                                   mismatch_count,
   output int                                   points_pending
);
   import dtpp_pkg::*;

   localparam longint XY_TOP = (longint'(1) <<< (XY_W - 1)) - 1;
   localparam longint XY_BOT = -(longint'(1) <<< (XY_W - 1));
   localparam int     REPORT_LIMIT = 10;

   // Shadow copy of the camera registers
   logic [CSR_W-1:0] focal_q4;
   logic [CSR_W-1:0] baseline_len;
   logic [CSR_W-1:0] center_x_q4;
   logic [CSR_W-1:0] center_y_q4;
   logic [CSR_W-1:0] max_depth;

   // Points owed by the block, oldest first
   point_type points_due[$];

   // Offset times depth over focal, truncated toward zero, then saturated
   function automatic logic [XY_W-1:0] scale_by_focal(input longint offset_q4,
                                                       input longint depth_q4);
      longint focal_l;
      longint quot;
      focal_l = focal_q4;
      if (focal_l == 0) return '0;
      quot = (offset_q4 * depth_q4) / focal_l;
      if (quot > XY_TOP) quot = XY_TOP;
      if (quot < XY_BOT) quot = XY_BOT;
      return quot[XY_W-1:0];
   endfunction

   // Expected point for one pixel under the current registers
   function automatic point_type project_pixel(input logic [COORD_W-1:0] col,
                                               input logic [COORD_W-1:0] rw,
                                               input logic signed [DISP_W-1:0] disp,
                                               input logic [COLOR_W-1:0] red,
                                               input logic [COLOR_W-1:0] green,
                                               input logic [COLOR_W-1:0] blue);
      point_type pt;
      longint    disp_l;
      longint    col_l;
      longint    row_l;
      longint    cx_l;
      longint    cy_l;
      longint    depth_limit;
      longint    depth_q4;
      logic [63:0] depth_num;
      pt     = '0;
      pt.rgb = {red, green, blue};
      disp_l = disp;
      if (disp_l > 0) begin
         depth_num   = 64'd16 * focal_q4 * baseline_len;
         depth_q4    = depth_num / 64'(disp_l);
         depth_limit = max_depth;
         depth_limit = 16 * depth_limit;
         if (depth_q4 <= depth_limit) begin
            col_l = col;
            row_l = rw;
            cx_l  = center_x_q4;
            cy_l  = center_y_q4;
            pt.z  = depth_q4[Z_W-1:0];
            pt.x  = scale_by_focal(16 * col_l - cx_l, depth_q4);
            pt.y  = scale_by_focal(16 * row_l - cy_l, depth_q4);
            pt.pv = 1'b1;
         end
      end
      return pt;
   endfunction

   always @(posedge clock) begin : watch
      point_type seen;
      point_type want;
      if (reset) begin
         focal_q4     <= FOCAL_Q4_RESET;
         baseline_len <= BASELINE_RESET;
         center_x_q4  <= CENTER_X_Q4_RESET;
         center_y_q4  <= CENTER_Y_Q4_RESET;
         max_depth    <= MAX_DEPTH_RESET;
         points_due.delete();
      end else begin
         // register writes take effect for pixels after this edge
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FOCAL_Q4:    focal_q4     <= csr_wdata;
               CSR_BASELINE:    baseline_len <= csr_wdata;
               CSR_CENTER_X_Q4: center_x_q4  <= csr_wdata;
               CSR_CENTER_Y_Q4: center_y_q4  <= csr_wdata;
               CSR_MAX_DEPTH:   max_depth    <= csr_wdata;
               default: ;
            endcase
         end
         // pixel transfer: queue its point
         if (req_valid && !req_stall)
            points_due.push_back(project_pixel(req_column, req_row, req_disparity_q4,
                                               req_red, req_green, req_blue));
         // point transfer: compare with the oldest owed point
         if (rsp_valid && !rsp_stall) begin
            seen.x   = rsp_x_q4;
            seen.y   = rsp_y_q4;
            seen.z   = rsp_z_q4;
            seen.rgb = rsp_packed_rgb;
            seen.pv  = rsp_point_valid;
            if (points_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: point transfer with none owed", $time);
            end else begin
               want = points_due.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $write("%0t: point mismatch (exp/got) x %0d/%0d y %0d/%0d", $time,
                            $signed(want.x), $signed(seen.x),
                            $signed(want.y), $signed(seen.y));
                     $display(" z %0d/%0d rgb %06h/%06h valid %0b/%0b",
                              want.z, seen.z, want.rgb, seen.rgb, want.pv, seen.pv);
                  end
               end
            end
         end
      end
      points_pending = points_due.size();
   end

endmodule

// File: sim/disparity_to_point_projection_tb.sv
// Stimulus, watchdog and verdict for the disparity to point projection block.
module disparity_to_point_projection_tb;
   import dtpp_pkg::*;

   localparam int IDLE_LIMIT        = 2000;
   localparam int DRAIN_CYCLES      = 100;
   localparam int NUM_SETTINGS      = 9;
   localparam int PIXELS_PER_SETTING = 210;
   localparam int DISP_TOP          = (1 << (DISP_W - 1)) - 1;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_W-1:0]          csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [COORD_W-1:0]        req_column = '0;
   logic [COORD_W-1:0]        req_row = '0;
   logic signed [DISP_W-1:0]  req_disparity_q4 = '0;
   logic [COLOR_W-1:0]        req_red = '0;
   logic [COLOR_W-1:0]        req_green = '0;
   logic [COLOR_W-1:0]        req_blue = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [XY_W-1:0]    rsp_x_q4;
   logic signed [XY_W-1:0]    rsp_y_q4;
   logic [Z_W-1:0]            rsp_z_q4;
   logic [RGB_W-1:0]          rsp_packed_rgb;
   logic                      rsp_point_valid;

   int mismatch_count;
   int points_pending;
   int quiet_cycles = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   // Registers as last written, used to steer disparities toward valid depths
   logic [CSR_W-1:0] focal_now     = FOCAL_Q4_RESET;
   logic [CSR_W-1:0] baseline_now  = BASELINE_RESET;
   logic [CSR_W-1:0] max_depth_now = MAX_DEPTH_RESET;

   initial begin
      forever #5 clock = ~clock;
   end

   disparity_to_point_projection u_top (.*);

   dtpp_point_checker u_check (.*);

   // Random back-pressure on the point channel
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   // Watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One pixel transfer, with random idle cycles ahead of it
   task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] rw,
                             input logic [DISP_W-1:0] disp, input logic [COLOR_W-1:0] red,
                             input logic [COLOR_W-1:0] green, input logic [COLOR_W-1:0] blue);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_column       = col;
      req_row          = rw;
      req_disparity_q4 = disp;
      req_red          = red;
      req_green        = green;
      req_blue         = blue;
      req_valid        = 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending and wait until every owed point has come out
   task automatic drain_points();
      @(negedge clock);
      req_valid = 1'b0;
      while (points_pending != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Load all camera registers, then poke the unused indexes
   task automatic apply_setting(input logic [CSR_W-1:0] focal, input logic [CSR_W-1:0] base,
                                input logic [CSR_W-1:0] cx, input logic [CSR_W-1:0] cy,
                                input logic [CSR_W-1:0] max_d);
      write_csr(CSR_FOCAL_Q4, focal);
      write_csr(CSR_BASELINE, base);
      write_csr(CSR_CENTER_X_Q4, cx);
      write_csr(CSR_CENTER_Y_Q4, cy);
      write_csr(CSR_MAX_DEPTH, max_d);
      for (int k = int'(CSR_MAX_DEPTH) + 1; k < (1 << CSR_IDX_W); k++)
         write_csr(CSR_IDX_W'(k), CSR_W'($urandom));
      focal_now     = focal;
      baseline_now  = base;
      max_depth_now = max_d;
   endtask

   // Register value biased toward both ends of the range
   function automatic logic [CSR_W-1:0] random_register();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return CSR_W'($urandom);
      endcase
   endfunction

   // Mostly disparities that land within the depth limit, some near its edge,
   // the rest anything (zero and negative included)
   function automatic logic [DISP_W-1:0] pick_disparity();
      longint depth_num;
      longint max_l;
      longint least_ok;
      int     roll;
      depth_num = 64'd16 * focal_now * baseline_now;
      max_l     = max_depth_now;
      least_ok  = depth_num / (16 * max_l + 1) + 1;
      roll      = $urandom_range(0, 99);
      if (roll < 25 || least_ok > DISP_TOP)
         return DISP_W'($urandom);
      else if (roll < 40)
         return DISP_W'(least_ok - 2 + $urandom_range(0, 4));
      else
         return DISP_W'($urandom_range(int'(least_ok), DISP_TOP));
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         // receiver-heavy idling, then sender-heavy, then none
         case (s / 3)
            0:       begin req_idle_pct = 19; rsp_idle_pct = 55; end
            1:       begin req_idle_pct = 55; rsp_idle_pct = 19; end
            default: begin req_idle_pct = 0;  rsp_idle_pct = 0;  end
         endcase
         if (s > 0) drain_points();
         case (s)
            0: ;  // reset values
            1: apply_setting(16'd0, 16'd100, 16'h8000, 16'h1234, 16'd20000);
            2: apply_setting(16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
            3: apply_setting(16'hFFFF, 16'd31, 16'd0, 16'hFFFF, 16'hFFFF);
            4: apply_setting(16'd16000, 16'd0, 16'hFFFF, 16'd0, 16'd0);
            default: apply_setting(random_register(),
                                   ($urandom_range(0, 3) == 0) ? random_register()
                                                               : CSR_W'($urandom_range(0, 400)),
                                   random_register(), random_register(),
                                   ($urandom_range(0, 2) == 0) ? random_register() : '1);
         endcase

         if (s == 0) begin
            // zero and negative disparity, depth limit on both sides, field extremes
            send_pixel(12'd0,    12'd0,    12'd0,    8'h00, 8'h00, 8'h00);
            send_pixel(12'hFFF,  12'hFFF,  12'hFFF,  8'hFF, 8'hFF, 8'hFF);
            send_pixel(12'd2048, 12'd1,    12'h800,  8'hAA, 8'h55, 8'h0F);
            send_pixel(12'd100,  12'd200,  12'd1,    8'h01, 8'h02, 8'h03);
            send_pixel(12'd5,    12'd6,    12'd79,   8'h10, 8'h20, 8'h30);
            send_pixel(12'd7,    12'd8,    12'd80,   8'h40, 8'h50, 8'h60);
            send_pixel(12'hFFF,  12'hFFF,  12'd2047, 8'hFF, 8'h00, 8'hFF);
            send_pixel(12'd0,    12'd0,    12'd2047, 8'h00, 8'hFF, 8'h00);
            send_pixel(12'd9,    12'd10,   12'd16,   8'h11, 8'h22, 8'h33);
            send_pixel(12'd2047, 12'd2048, 12'd1024, 8'h7F, 8'h80, 8'hC3);
            send_pixel(12'd1,    12'd4094, 12'd81,   8'hFE, 8'h01, 8'h3C);
            send_pixel(12'hAAA,  12'h555,  12'h555,  8'h80, 8'h7F, 8'h01);
         end else if (s == 2) begin
            // unit focal: depth at its limit, X and Y saturating both ways
            send_pixel(12'd0,    12'hFFF,  12'd1,    8'h12, 8'h34, 8'h56);
            send_pixel(12'hFFF,  12'd0,    12'd2047, 8'h65, 8'h43, 8'h21);
            send_pixel(12'hFFF,  12'hFFF,  12'd16,   8'h0A, 8'hB0, 8'h0C);
            send_pixel(12'd3,    12'd4,    12'h800,  8'hDE, 8'hAD, 8'hBE);
         end

         for (int n = 0; n < PIXELS_PER_SETTING; n++)
            send_pixel(COORD_W'($urandom), COORD_W'($urandom), pick_disparity(),
                       COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
      end

      drain_points();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && points_pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
